>>> rtl/core/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared codes and types of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STOP  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic CSR_HALF_PERIOD   = 1'b0;
   localparam logic CSR_STRETCH_LIMIT = 1'b1;

   localparam logic [7:0] HALF_PERIOD_RESET   = 8'd10;
   localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd255;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] func;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic       scl_line;
      logic       sda_line;
   } item_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack;
      logic       timed_out;
   } result_type;

endpackage

>>> rtl/core/i2cmbe_core.sv
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus sequencer state and the per-tick step logic of the byte engine.
// ----------------------------------------------------------------------------
module i2cmbe_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  i2cmbe_pkg::item_type   item,
   input  logic [7:0]             half_period,
   input  logic [7:0]             stretch_limit,
   output i2cmbe_pkg::result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_W1   = 3'd1,
      PH_POLL = 3'd2,
      PH_W2   = 3'd3,
      PH_HOLD = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic [7:0] stretch_ff, stretch_in;
   logic       scl_low_ff, scl_low_in;
   logic       sda_low_ff, sda_low_in;
   logic       ack_hold_ff, ack_hold_in;
   logic       tmo_ff, tmo_in;

   logic       delay_over;
   logic       stretch_over;
   logic [3:0] bit_next;
   logic [7:0] shift_next;

   assign delay_over   = ({1'b0, delay_ff} + 9'd1) >= {1'b0, half_period};
   assign stretch_over = ({1'b0, stretch_ff} + 9'd1) >= {1'b0, stretch_limit};
   assign bit_next     = bit_count_ff + 4'd1;
   assign shift_next   = (cmd_ff == i2cmbe_pkg::FUNC_WRITE) ? {shift_ff[6:0], 1'b0}
                                                            : {shift_ff[6:0], item.sda_line};

   always_comb begin
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      stretch_in   = stretch_ff;
      scl_low_in   = scl_low_ff;
      sda_low_in   = sda_low_ff;
      ack_hold_in  = ack_hold_ff;
      tmo_in       = tmo_ff;
      res.done_res  = 1'b0;
      res.rx_byte   = 8'd0;
      res.nack      = 1'b0;
      res.timed_out = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (item.cmd_valid) begin
               cmd_in       = item.func;
               bit_count_in = 4'd0;
               tmo_in       = 1'b0;
               case (item.func)
                  i2cmbe_pkg::FUNC_START: sda_low_in = 1'b0;
                  i2cmbe_pkg::FUNC_STOP:  sda_low_in = 1'b1;
                  i2cmbe_pkg::FUNC_WRITE: begin
                     shift_in   = item.tx_byte;
                     sda_low_in = ~item.tx_byte[7];
                  end
                  default: begin
                     shift_in    = 8'd0;
                     ack_hold_in = item.ack_level;
                     sda_low_in  = 1'b0;
                  end
               endcase
               phase_in   = PH_W1;
               delay_in   = 8'd0;
               stretch_in = 8'd0;
            end
         end
         PH_W1: begin
            if (delay_over) begin
               scl_low_in = 1'b0;
               phase_in   = PH_POLL;
               delay_in   = 8'd0;
               stretch_in = 8'd0;
            end else begin
               delay_in = delay_ff + 8'd1;
            end
         end
         PH_POLL: begin
            if (item.scl_line || stretch_over) begin
               tmo_in     = tmo_ff | ~item.scl_line;
               phase_in   = PH_W2;
               delay_in   = 8'd0;
               stretch_in = 8'd0;
            end else begin
               stretch_in = stretch_ff + 8'd1;
            end
         end
         PH_W2: begin
            if (!delay_over) begin
               delay_in = delay_ff + 8'd1;
            end else begin
               delay_in   = 8'd0;
               stretch_in = 8'd0;
               if (cmd_ff == i2cmbe_pkg::FUNC_START) begin
                  sda_low_in = 1'b1;
                  phase_in   = PH_HOLD;
               end else if (cmd_ff == i2cmbe_pkg::FUNC_STOP) begin
                  sda_low_in = 1'b0;
                  phase_in   = PH_HOLD;
               end else if (tmo_ff) begin
                  res.done_res  = 1'b1;
                  res.timed_out = 1'b1;
                  res.nack      = (cmd_ff == i2cmbe_pkg::FUNC_WRITE);
                  phase_in      = PH_IDLE;
               end else if (bit_count_ff < i2cmbe_pkg::BITS_PER_BYTE) begin
                  shift_in     = shift_next;
                  bit_count_in = bit_next;
                  scl_low_in   = 1'b1;
                  if (bit_next < i2cmbe_pkg::BITS_PER_BYTE) begin
                     if (cmd_ff == i2cmbe_pkg::FUNC_WRITE) sda_low_in = ~shift_next[7];
                  end else if (cmd_ff == i2cmbe_pkg::FUNC_WRITE) begin
                     sda_low_in = 1'b0;
                  end else begin
                     sda_low_in = ~ack_hold_ff;
                  end
                  phase_in = PH_W1;
               end else begin
                  scl_low_in   = 1'b1;
                  res.done_res = 1'b1;
                  if (cmd_ff == i2cmbe_pkg::FUNC_WRITE) res.nack = item.sda_line;
                  else res.rx_byte = shift_ff;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_HOLD: begin
            if (!delay_over) begin
               delay_in = delay_ff + 8'd1;
            end else begin
               if (cmd_ff == i2cmbe_pkg::FUNC_START) scl_low_in = 1'b1;
               res.done_res = 1'b1;
               phase_in     = PH_IDLE;
               delay_in     = 8'd0;
               stretch_in   = 8'd0;
            end
         end
         default: begin
            phase_in   = PH_IDLE;
            delay_in   = 8'd0;
            stretch_in = 8'd0;
         end
      endcase
      res.scl_drive_low = scl_low_in;
      res.sda_drive_low = sda_low_in;
      res.busy_res      = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cmd_ff       <= 2'd0;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         delay_ff     <= 8'd0;
         stretch_ff   <= 8'd0;
         scl_low_ff   <= 1'b0;
         sda_low_ff   <= 1'b0;
         ack_hold_ff  <= 1'b0;
         tmo_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         cmd_ff       <= cmd_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         delay_ff     <= delay_in;
         stretch_ff   <= stretch_in;
         scl_low_ff   <= scl_low_in;
         sda_low_ff   <= sda_low_in;
         ack_hold_ff  <= ack_hold_in;
         tmo_ff       <= tmo_in;
      end
   end

   a_byte_bound: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= i2cmbe_pkg::BITS_PER_BYTE)
      else $error("bit count past one byte");

   a_poll_released: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_POLL |-> !scl_low_ff)
      else $error("scl driven while polling");

   a_idle_scl_step: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_W1 && delay_over |=> phase_ff == PH_POLL && !scl_low_ff)
      else $error("scl not released after first wait");

endmodule

>>> rtl/core/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master stepped once per accepted tick transaction.
// ----------------------------------------------------------------------------
// Each req_ transaction is one bus tick: sampled scl/sda levels plus an
// optional command (start, stop, write byte, read byte). Each tick yields
// exactly one rsp_ transaction with the pin drives after that tick, busy,
// a done pulse and the command result (rx byte, nack, timed_out).
// The csr_ port writes half_period (index 0) and stretch_limit (index 1);
// write only while the engine is idle.
// An input register feeds the step logic, which loads the output register that
// drives rsp_. Throughput is one tick per cycle with no gap while the receiver
// takes each rsp_ as it is offered.
// When the receiver stalls, the output register holds and the input register
// takes one more tick, then req_ready drops until rsp_ is taken.
// Reset (synchronous) releases both lines, sets the engine idle, empties both
// registers and restores half_period 10 and stretch_limit 255.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd_valid,
   input  logic [1:0] req_func,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_level,
   input  logic       req_scl_line,
   input  logic       req_sda_line,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_drive_low,
   output logic       rsp_sda_drive_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_nack,
   output logic       rsp_timed_out,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   i2cmbe_pkg::item_type   item_ff;
   i2cmbe_pkg::result_type step_res;
   i2cmbe_pkg::result_type res_ff;
   logic                   s1_valid_ff;
   logic                   out_valid_ff;
   logic                   advance;
   logic [7:0]             half_period_ff;
   logic [7:0]             stretch_limit_ff;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= i2cmbe_pkg::HALF_PERIOD_RESET;
         stretch_limit_ff <= i2cmbe_pkg::STRETCH_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cmbe_pkg::CSR_HALF_PERIOD:   half_period_ff   <= csr_wdata;
            i2cmbe_pkg::CSR_STRETCH_LIMIT: stretch_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.cmd_valid <= req_cmd_valid;
         item_ff.func      <= req_func;
         item_ff.tx_byte   <= req_tx_byte;
         item_ff.ack_level <= req_ack_level;
         item_ff.scl_line  <= req_scl_line;
         item_ff.sda_line  <= req_sda_line;
      end
      if (advance) res_ff <= step_res;
   end

   i2cmbe_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .item          (item_ff),
      .half_period   (half_period_ff),
      .stretch_limit (stretch_limit_ff),
      .res           (step_res)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_scl_drive_low = res_ff.scl_drive_low;
   assign rsp_sda_drive_low = res_ff.sda_drive_low;
   assign rsp_busy_res      = res_ff.busy_res;
   assign rsp_done_res      = res_ff.done_res;
   assign rsp_rx_byte       = res_ff.rx_byte;
   assign rsp_nack          = res_ff.nack;
   assign rsp_timed_out     = res_ff.timed_out;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   a_result_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_timed_out || rsp_nack || rsp_rx_byte != 8'd0) |-> rsp_done_res)
      else $error("result fields set without done");

   a_timeout_scl_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> !rsp_scl_drive_low)
      else $error("scl held low after timeout");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ready |=> s1_valid_ff && out_valid_ff)
      else $error("transaction lost during stall");

endmodule

>>> tb/sv/i2c_master_byte_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the I2C master byte engine.
// ----------------------------------------------------------------------------
// Every req_ transaction is one bus tick. A bit-exact model of the engine
// steps on each accepted tick and queues the expected rsp_ transaction.
// A short directed sequence runs first, with zero timing registers, bus
// timeouts and a command sent while busy. Random phases follow under several
// timing settings. In those phases a simple bus model answers the engine:
// SCL follows the drive with random clock stretching, and slave data and ACKs
// are random. Most commands form start / byte / stop sequences.
// Both channels idle at random, except in one phase where neither idles.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_PHASES = 7;
   localparam int QUIET_PHASE = 4;
   localparam int PRESSURE_PHASE = 1;
   localparam logic [7:0] PH_HALF [N_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd1, 8'd10, 8'd32};
   localparam logic [7:0] PH_STRETCH [N_PHASES] = '{8'd255, 8'd3, 8'd2, 8'd1, 8'd8, 8'd255,
                                                    8'd255};
   localparam int PH_ITEMS [N_PHASES] = '{200, 250, 150, 150, 250, 100, 50};

   typedef enum logic [2:0] {
      BUS_IDLE, BUS_RISE_WAIT, BUS_SCL_POLL, BUS_FALL_WAIT, BUS_COND_HOLD
   } bus_step_type;

   typedef struct packed {
      i2cmbe_pkg::item_type   stim;
      logic                   pinned;
      i2cmbe_pkg::result_type want;
   } vector_type;

   // timing registers are zero here: one-tick delays, timeout on the first low poll
   localparam int N_DIRECTED = 20;
   localparam vector_type DIRECTED [N_DIRECTED] = '{
      '{'{1'b0, i2cmbe_pkg::FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b1, i2cmbe_pkg::FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b1, i2cmbe_pkg::FUNC_STOP,  8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0}},
      '{'{1'b1, i2cmbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0}},
      '{'{1'b1, i2cmbe_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1}},
      '{'{1'b1, i2cmbe_pkg::FUNC_READ,  8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_READ,  8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_READ,  8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b0, i2cmbe_pkg::FUNC_READ,  8'h00, 1'b1, 1'b0, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1}},
      '{'{1'b1, i2cmbe_pkg::FUNC_WRITE, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0}
   };

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd_valid = 1'b0;
   logic [1:0] req_func = i2cmbe_pkg::FUNC_START;
   logic [7:0] req_tx_byte = 8'h00;
   logic       req_ack_level = 1'b0;
   logic       req_scl_line = 1'b1;
   logic       req_sda_line = 1'b1;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_scl_drive_low;
   logic       rsp_sda_drive_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_nack;
   logic       rsp_timed_out;
   logic       csr_we = 1'b0;
   logic       csr_index = i2cmbe_pkg::CSR_HALF_PERIOD;
   logic [7:0] csr_wdata = 8'h00;

   // engine model state
   bus_step_type m_step = BUS_IDLE;
   logic [1:0]   m_func = i2cmbe_pkg::FUNC_START;
   logic [3:0]   m_bits = 4'd0;
   logic [7:0]   m_shift = 8'h00;
   logic [7:0]   m_delay = 8'h00;
   logic [7:0]   m_stretch = 8'h00;
   logic         m_scl_low = 1'b0;
   logic         m_sda_low = 1'b0;
   logic         m_ack_level = 1'b0;
   logic         m_timeout = 1'b0;
   logic [7:0]   cfg_half = i2cmbe_pkg::HALF_PERIOD_RESET;
   logic [7:0]   cfg_stretch = i2cmbe_pkg::STRETCH_LIMIT_RESET;

   i2cmbe_pkg::result_type pending_results[$];
   logic                   pin_next = 1'b0;
   i2cmbe_pkg::result_type pin_want = '0;
   logic                   quiet = 1'b0;
   logic                   in_xfer = 1'b0;
   int                     xfer_left = 0;
   logic                   hold_scl = 1'b0;
   int                     fail_count = 0;
   int                     cycle_count = 0;

   i2c_master_byte_engine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd_valid(req_cmd_valid),
      .req_func(req_func),
      .req_tx_byte(req_tx_byte),
      .req_ack_level(req_ack_level),
      .req_scl_line(req_scl_line),
      .req_sda_line(req_sda_line),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scl_drive_low(rsp_scl_drive_low),
      .rsp_sda_drive_low(rsp_sda_drive_low),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_rx_byte(rsp_rx_byte),
      .rsp_nack(rsp_nack),
      .rsp_timed_out(rsp_timed_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic half_done();
      return ({1'b0, m_delay} + 9'd1) >= {1'b0, cfg_half};
   endfunction

   function automatic void goto_step(input bus_step_type nxt);
      m_step = nxt;
      m_delay = 8'h00;
      m_stretch = 8'h00;
   endfunction

   function automatic i2cmbe_pkg::result_type predict_tick(input i2cmbe_pkg::item_type t);
      i2cmbe_pkg::result_type r;
      r = '0;
      case (m_step)
         BUS_IDLE: begin
            if (t.cmd_valid) begin
               m_func = t.func;
               m_bits = 4'd0;
               m_timeout = 1'b0;
               case (t.func)
                  i2cmbe_pkg::FUNC_START: m_sda_low = 1'b0;
                  i2cmbe_pkg::FUNC_STOP: m_sda_low = 1'b1;
                  i2cmbe_pkg::FUNC_WRITE: begin
                     m_shift = t.tx_byte;
                     m_sda_low = ~t.tx_byte[7];
                  end
                  default: begin
                     m_shift = 8'h00;
                     m_ack_level = t.ack_level;
                     m_sda_low = 1'b0;
                  end
               endcase
               goto_step(BUS_RISE_WAIT);
            end
         end
         BUS_RISE_WAIT: begin
            if (half_done()) begin
               m_scl_low = 1'b0;
               goto_step(BUS_SCL_POLL);
            end else begin
               m_delay++;
            end
         end
         BUS_SCL_POLL: begin
            if (t.scl_line) begin
               goto_step(BUS_FALL_WAIT);
            end else if (({1'b0, m_stretch} + 9'd1) >= {1'b0, cfg_stretch}) begin
               m_timeout = 1'b1;
               goto_step(BUS_FALL_WAIT);
            end else begin
               m_stretch++;
            end
         end
         BUS_FALL_WAIT: begin
            if (!half_done()) begin
               m_delay++;
            end else if (m_func == i2cmbe_pkg::FUNC_START) begin
               m_sda_low = 1'b1;
               goto_step(BUS_COND_HOLD);
            end else if (m_func == i2cmbe_pkg::FUNC_STOP) begin
               m_sda_low = 1'b0;
               goto_step(BUS_COND_HOLD);
            end else if (m_timeout) begin
               r.done_res = 1'b1;
               r.timed_out = 1'b1;
               r.nack = (m_func == i2cmbe_pkg::FUNC_WRITE);
               goto_step(BUS_IDLE);
            end else if (m_bits < i2cmbe_pkg::BITS_PER_BYTE) begin
               if (m_func == i2cmbe_pkg::FUNC_WRITE) m_shift = {m_shift[6:0], 1'b0};
               else m_shift = {m_shift[6:0], t.sda_line};
               m_bits++;
               m_scl_low = 1'b1;
               if (m_bits < i2cmbe_pkg::BITS_PER_BYTE) begin
                  if (m_func == i2cmbe_pkg::FUNC_WRITE) m_sda_low = ~m_shift[7];
               end else if (m_func == i2cmbe_pkg::FUNC_WRITE) begin
                  m_sda_low = 1'b0;
               end else begin
                  m_sda_low = ~m_ack_level;
               end
               goto_step(BUS_RISE_WAIT);
            end else begin
               m_scl_low = 1'b1;
               r.done_res = 1'b1;
               if (m_func == i2cmbe_pkg::FUNC_WRITE) r.nack = t.sda_line;
               else r.rx_byte = m_shift;
               goto_step(BUS_IDLE);
            end
         end
         BUS_COND_HOLD: begin
            if (!half_done()) begin
               m_delay++;
            end else begin
               if (m_func == i2cmbe_pkg::FUNC_START) m_scl_low = 1'b1;
               r.done_res = 1'b1;
               goto_step(BUS_IDLE);
            end
         end
         default: goto_step(BUS_IDLE);
      endcase
      r.scl_drive_low = m_scl_low;
      r.sda_drive_low = m_sda_low;
      r.busy_res = (m_step != BUS_IDLE);
      return r;
   endfunction

   // next tick as the bus and the command source would present it
   function automatic i2cmbe_pkg::item_type bus_tick(input logic may_issue);
      i2cmbe_pkg::item_type t;
      int roll;
      t.cmd_valid = 1'b0;
      t.func = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 9);
      t.tx_byte = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      t.ack_level = 1'($urandom_range(0, 1));
      if (m_scl_low) t.scl_line = 1'b0;
      else if (m_step == BUS_SCL_POLL) t.scl_line = !(hold_scl || $urandom_range(0, 99) < 25);
      else t.scl_line = 1'b1;
      if (m_sda_low) begin
         t.sda_line = 1'b0;
      end else if (m_step != BUS_IDLE && m_func == i2cmbe_pkg::FUNC_READ &&
                   m_bits < i2cmbe_pkg::BITS_PER_BYTE) begin
         t.sda_line = 1'($urandom_range(0, 1));
      end else if (m_step != BUS_IDLE && m_func == i2cmbe_pkg::FUNC_WRITE &&
                   m_bits == i2cmbe_pkg::BITS_PER_BYTE) begin
         t.sda_line = ($urandom_range(0, 99) < 25);
      end else begin
         t.sda_line = 1'b1;
      end
      if ($urandom_range(0, 99) < 4) begin
         t.scl_line = 1'($urandom_range(0, 1));
         t.sda_line = 1'($urandom_range(0, 1));
      end
      if (may_issue && m_step != BUS_IDLE) begin
         t.cmd_valid = ($urandom_range(0, 99) < 10);
      end else if (may_issue && $urandom_range(0, 99) < 70) begin
         t.cmd_valid = 1'b1;
         hold_scl = ($urandom_range(0, 99) < 6);
         if ($urandom_range(0, 99) >= 8) begin
            if (!in_xfer) begin
               in_xfer = 1'b1;
               xfer_left = $urandom_range(1, 3);
               t.func = i2cmbe_pkg::FUNC_START;
            end else if (xfer_left == 0) begin
               in_xfer = 1'b0;
               t.func = i2cmbe_pkg::FUNC_STOP;
            end else begin
               xfer_left--;
               t.func = $urandom_range(0, 1) ? i2cmbe_pkg::FUNC_WRITE : i2cmbe_pkg::FUNC_READ;
            end
         end
      end
      return t;
   endfunction

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      i2cmbe_pkg::result_type got;
      i2cmbe_pkg::result_type want;
      i2cmbe_pkg::result_type model;
      i2cmbe_pkg::item_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_scl_drive_low, rsp_sda_drive_low, rsp_busy_res, rsp_done_res,
                   rsp_rx_byte, rsp_nack, rsp_timed_out};
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected transaction, expected none actual %0h",
                        $time, got);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(got.scl_drive_low));
               check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(got.sda_drive_low));
               check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(got.done_res));
               check_field("rx_byte", want.rx_byte, got.rx_byte);
               check_field("nack", 8'(want.nack), 8'(got.nack));
               check_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
            end
         end
         if (req_valid && req_ready) begin
            seen = {req_cmd_valid, req_func, req_tx_byte, req_ack_level, req_scl_line,
                    req_sda_line};
            model = predict_tick(seen);
            pending_results.push_back(pin_next ? pin_want : model);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 17);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic idle_gaps();
      while (!quiet && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drive_tick(input i2cmbe_pkg::item_type t);
      req_valid <= 1'b1;
      req_cmd_valid <= t.cmd_valid;
      req_func <= t.func;
      req_tx_byte <= t.tx_byte;
      req_ack_level <= t.ack_level;
      req_scl_line <= t.scl_line;
      req_sda_line <= t.sda_line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_to_idle();
      while (m_step != BUS_IDLE) begin
         idle_gaps();
         drive_tick(bus_tick(1'b0));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_timing(input logic [7:0] half, input logic [7:0] stretch);
      csr_we <= 1'b1;
      csr_index <= i2cmbe_pkg::CSR_HALF_PERIOD;
      csr_wdata <= half;
      @(negedge clock);
      csr_index <= i2cmbe_pkg::CSR_STRETCH_LIMIT;
      csr_wdata <= stretch;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      cfg_half = half;
      cfg_stretch = stretch;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      load_timing(8'd0, 8'd0);
      for (int k = 0; k < N_DIRECTED; k++) begin
         idle_gaps();
         pin_next = DIRECTED[k].pinned;
         pin_want = DIRECTED[k].want;
         drive_tick(DIRECTED[k].stim);
      end
      pin_next = 1'b0;
      run_to_idle();
      settle();

      for (int p = 0; p < N_PHASES; p++) begin
         load_timing(PH_HALF[p], PH_STRETCH[p]);
         quiet = (p == QUIET_PHASE);
         in_xfer = 1'b0;
         for (int n = 0; n < PH_ITEMS[p]; n++) begin
            if (p == PRESSURE_PHASE && n == PH_ITEMS[p] / 2) begin
               req_valid <= 1'b0;
               do @(negedge clock); while (pending_results.size() != 0);
            end
            idle_gaps();
            drive_tick(bus_tick(1'b1));
         end
         run_to_idle();
         quiet = 1'b0;
         settle();
      end

      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_core.sv
rtl/core/i2c_master_byte_engine.sv
tb/sv/i2c_master_byte_engine_tb.sv
